// ----- design/srs_pkg.sv -----
// Shared types and constants for the sensor run statistics block.
package srs_pkg;

    // Field widths fixed by the interface
    localparam int unsigned READING_W = 16;
    localparam int unsigned LEVEL_W   = 15;
    localparam int unsigned OUT_CNT_W = 11;
    localparam int unsigned OUT_IDX_W = 10;
    localparam int unsigned CFG_IDX_W = 2;

    // Average never exceeds the largest reading, so 15 quotient bits suffice
    localparam int unsigned QUOT_W    = LEVEL_W;
    localparam int unsigned STEP_W    = $clog2(QUOT_W);

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_WARN_LEVEL     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CRIT_LEVEL     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHUTDOWN_LEVEL = 2'd2;

    // Threshold reset values
    localparam logic [LEVEL_W-1:0] WARN_RESET     = 15'd480;
    localparam logic [LEVEL_W-1:0] CRIT_RESET     = 15'd720;
    localparam logic [LEVEL_W-1:0] SHUTDOWN_RESET = 15'd960;

    // Bin codes
    typedef enum logic [1:0] {
        BIN_NORMAL   = 2'd0,
        BIN_WARNING  = 2'd1,
        BIN_CRITICAL = 2'd2,
        BIN_SHUTDOWN = 2'd3
    } bin_t;

    // Top level sequencer
    typedef enum logic [1:0] {
        ST_RUN,
        ST_DIV,
        ST_OUT
    } state_t;

    // Divider status towards the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ----- design/srs_div.sv -----
// Restoring divider, one quotient bit per cycle, for the run average.
module srs_div
    import srs_pkg::*;
#(
    parameter int unsigned CNT_W = 11
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [CNT_W+QUOT_W-1:0]  dividend,
    input  logic [CNT_W-1:0]         divisor,
    output div_stat_t                stat,
    output logic [QUOT_W-1:0]        quotient
);

    localparam int unsigned W = CNT_W + QUOT_W;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [W-1:0]      rem_reg, rem_next;
    logic [W-1:0]      den_reg, den_next;
    logic [QUOT_W-1:0] quot_reg, quot_next;
    logic              fits;

    // One trial subtraction per cycle
    assign fits = (rem_reg >= den_reg);

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = STEP_W'(QUOT_W - 1);
            rem_next  = dividend;
            den_next  = {1'b0, divisor, {(QUOT_W-1){1'b0}}};
            quot_next = '0;
        end else if (busy_reg) begin
            rem_next  = fits ? (rem_reg - den_reg) : rem_reg;
            den_next  = den_reg >> 1;
            quot_next = {quot_reg[QUOT_W-2:0], fits};
            step_next = step_reg - 1'b1;
            if (step_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // Datapath, no reset needed
    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quot_reg;

`ifndef NO_ASSERTIONS
    // A new division is never started over one in flight
    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !start)
        else $error("divider restarted while busy");

    // Completion follows in the cycle after the final step
    a_done_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && !start && step_reg == '0) |=> (done_reg && !busy_reg))
        else $error("divider did not finish after last step");
`endif

endmodule

// ----- design/sensor_run_statistics.sv -----
// Sensor run statistics: top level with run accumulators and result register.
//
// Input channel (s_*): one temperature word per handshake, signed 1/16 degree
// units, with s_last_of_run on the final word of a run. Negative words count
// as sensor errors. Ordinary words are taken one per cycle.
// Result channel (m_*): one summary word per run, holding min, max, average,
// bin counts, error count and the index of the first critical reading.
// Config port: cfg_we writes cfg_wdata into threshold cfg_idx
// (0 warn, 1 crit, 2 shutdown); other indexes are ignored. Write only while
// the block is idle.
// The last word of a run starts the bit-serial division for the average, one
// quotient bit per cycle; s_ready stays low until the summary is loaded into
// the result register.
// A finished summary waits in the output register while the next run streams
// in; if it is still not taken when the next summary is ready, the block
// holds s_ready low until m_ready frees the register.
// Reset (aresetn, synchronous, active low) clears the run state, empties the
// result register and restores the threshold defaults.
module sensor_run_statistics
    import srs_pkg::*;
#(
    parameter int unsigned MAX_READINGS = 1024
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration
    input  logic                         cfg_we,
    input  logic [CFG_IDX_W-1:0]         cfg_idx,
    input  logic [LEVEL_W-1:0]           cfg_wdata,
    // input channel
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [READING_W-1:0]  s_reading,
    input  logic                         s_last_of_run,
    // result channel
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [LEVEL_W-1:0]           m_min_reading,
    output logic [LEVEL_W-1:0]           m_max_reading,
    output logic [LEVEL_W-1:0]           m_avg_reading,
    output logic                         m_any_valid,
    output logic [OUT_CNT_W-1:0]         m_skipped_count,
    output logic [OUT_CNT_W-1:0]         m_normal_count,
    output logic [OUT_CNT_W-1:0]         m_warning_count,
    output logic [OUT_CNT_W-1:0]         m_critical_count,
    output logic [OUT_CNT_W-1:0]         m_shutdown_count,
    output logic [OUT_IDX_W-1:0]         m_first_critical_index,
    output logic                         m_critical_seen
);

    localparam int unsigned CNT_W = $clog2(MAX_READINGS + 1);
    localparam int unsigned IDX_W = $clog2(MAX_READINGS);
    localparam int unsigned SUM_W = CNT_W + QUOT_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_READINGS);

    // Counter to output width: zero-extend, then keep the low bits
    function automatic logic [OUT_CNT_W-1:0] cnt_out(input logic [CNT_W-1:0] c);
        logic [CNT_W+OUT_CNT_W-1:0] ext;
        ext = {{OUT_CNT_W{1'b0}}, c};
        return ext[OUT_CNT_W-1:0];
    endfunction

    function automatic logic [OUT_IDX_W-1:0] idx_out(input logic [IDX_W-1:0] i);
        logic [IDX_W+OUT_IDX_W-1:0] ext;
        ext = {{OUT_IDX_W{1'b0}}, i};
        return ext[OUT_IDX_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c < CNT_MAX) ? c + 1'b1 : c;
    endfunction

    // Thresholds
    logic [LEVEL_W-1:0] warn_reg, crit_reg, shut_reg;

    // Run state
    logic [LEVEL_W-1:0] min_reg, min_next;
    logic [LEVEL_W-1:0] max_reg, max_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [CNT_W-1:0]   vcnt_reg, vcnt_next;
    logic [CNT_W-1:0]   item_reg, item_next;
    logic [CNT_W-1:0]   err_reg, err_next;
    logic [CNT_W-1:0]   bin_reg [4];
    logic [CNT_W-1:0]   bin_next [4];
    logic [IDX_W-1:0]   fpos_reg, fpos_next;
    logic               found_reg, found_next;

    // Sequencer
    state_t state_reg, state_next;
    logic   s_accept, out_slot, out_load, div_start;

    // Result register
    logic               m_valid_reg;
    logic [LEVEL_W-1:0] res_min_reg, res_max_reg, res_avg_reg;
    logic               res_any_reg, res_seen_reg;
    logic [OUT_CNT_W-1:0] res_err_reg, res_norm_reg, res_warn_reg;
    logic [OUT_CNT_W-1:0] res_crit_reg, res_shut_reg;
    logic [OUT_IDX_W-1:0] res_fpos_reg;

    div_stat_t          div_stat;
    logic [QUOT_W-1:0]  div_quot;

    logic               neg;
    logic [LEVEL_W-1:0] r;
    bin_t               bin;

    assign neg = s_reading[READING_W-1];
    assign r   = s_reading[LEVEL_W-1:0];

    // Bin decision, in threshold order
    always_comb begin
        if (r < warn_reg) begin
            bin = BIN_NORMAL;
        end else if (r < crit_reg) begin
            bin = BIN_WARNING;
        end else if (r < shut_reg) begin
            bin = BIN_CRITICAL;
        end else begin
            bin = BIN_SHUTDOWN;
        end
    end

    // Run accumulator update for one accepted word
    always_comb begin
        min_next   = min_reg;
        max_next   = max_reg;
        sum_next   = sum_reg;
        vcnt_next  = vcnt_reg;
        item_next  = item_reg;
        err_next   = err_reg;
        fpos_next  = fpos_reg;
        found_next = found_reg;
        for (int b = 0; b < 4; b++) begin
            bin_next[b] = bin_reg[b];
        end
        if (s_accept) begin
            if (neg) begin
                err_next = sat_inc(err_reg);
            end else begin
                if (vcnt_reg == '0 || r < min_reg) begin
                    min_next = r;
                end
                if (vcnt_reg == '0 || r > max_reg) begin
                    max_next = r;
                end
                if (vcnt_reg < CNT_MAX) begin
                    sum_next  = sum_reg + SUM_W'(r);
                    vcnt_next = vcnt_reg + 1'b1;
                end
                for (int b = 0; b < 4; b++) begin
                    if (bin == bin_t'(b)) begin
                        bin_next[b] = sat_inc(bin_reg[b]);
                    end
                end
                if (r >= crit_reg && !found_reg && item_reg < CNT_MAX) begin
                    found_next = 1'b1;
                    fpos_next  = item_reg[IDX_W-1:0];
                end
            end
            item_next = sat_inc(item_reg);
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_RUN: begin
                if (s_accept && s_last_of_run) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    state_next = out_slot ? ST_RUN : ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_slot) begin
                    state_next = ST_RUN;
                end
            end
            default: state_next = ST_RUN;
        endcase
    end

    // Sequencer outputs
    assign out_slot = !m_valid_reg || m_ready;
    always_comb begin
        s_ready  = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            ST_RUN:  s_ready  = 1'b1;
            ST_DIV:  out_load = div_stat.done && out_slot;
            ST_OUT:  out_load = out_slot;
            default: s_ready  = 1'b0;
        endcase
    end

    assign s_accept  = s_valid && s_ready;
    assign div_start = s_accept && s_last_of_run;

    // Average divider, fed with the values that include the last word
    srs_div #(
        .CNT_W (CNT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_next),
        .divisor  (vcnt_next),
        .stat     (div_stat),
        .quotient (div_quot)
    );

    // Thresholds
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            warn_reg <= WARN_RESET;
            crit_reg <= CRIT_RESET;
            shut_reg <= SHUTDOWN_RESET;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                REG_WARN_LEVEL:     warn_reg <= cfg_wdata;
                REG_CRIT_LEVEL:     crit_reg <= cfg_wdata;
                REG_SHUTDOWN_LEVEL: shut_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Run state; cleared once the summary is loaded
    always_ff @(posedge aclk) begin
        if (!aresetn || out_load) begin
            min_reg   <= '0;
            max_reg   <= '0;
            sum_reg   <= '0;
            vcnt_reg  <= '0;
            item_reg  <= '0;
            err_reg   <= '0;
            fpos_reg  <= '0;
            found_reg <= 1'b0;
            for (int b = 0; b < 4; b++) begin
                bin_reg[b] <= '0;
            end
        end else begin
            min_reg   <= min_next;
            max_reg   <= max_next;
            sum_reg   <= sum_next;
            vcnt_reg  <= vcnt_next;
            item_reg  <= item_next;
            err_reg   <= err_next;
            fpos_reg  <= fpos_next;
            found_reg <= found_next;
            for (int b = 0; b < 4; b++) begin
                bin_reg[b] <= bin_next[b];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_RUN;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Summary word
    always_ff @(posedge aclk) begin
        if (out_load) begin
            res_min_reg  <= min_reg;
            res_max_reg  <= max_reg;
            res_avg_reg  <= (vcnt_reg != '0) ? div_quot : '0;
            res_any_reg  <= (vcnt_reg != '0);
            res_err_reg  <= cnt_out(err_reg);
            res_norm_reg <= cnt_out(bin_reg[BIN_NORMAL]);
            res_warn_reg <= cnt_out(bin_reg[BIN_WARNING]);
            res_crit_reg <= cnt_out(bin_reg[BIN_CRITICAL]);
            res_shut_reg <= cnt_out(bin_reg[BIN_SHUTDOWN]);
            res_fpos_reg <= idx_out(fpos_reg);
            res_seen_reg <= found_reg;
        end
    end

    assign m_valid                = m_valid_reg;
    assign m_min_reading          = res_min_reg;
    assign m_max_reading          = res_max_reg;
    assign m_avg_reading          = res_avg_reg;
    assign m_any_valid            = res_any_reg;
    assign m_skipped_count        = res_err_reg;
    assign m_normal_count         = res_norm_reg;
    assign m_warning_count        = res_warn_reg;
    assign m_critical_count       = res_crit_reg;
    assign m_shutdown_count       = res_shut_reg;
    assign m_first_critical_index = res_fpos_reg;
    assign m_critical_seen        = res_seen_reg;

`ifndef NO_ASSERTIONS
    // No word is taken while the divider works on the run average
    a_no_accept_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.busy |-> !s_ready)
        else $error("input accepted during division");

    // Last word of a run hands over to the division
    a_last_to_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_last_of_run) |=> (state_reg == ST_DIV && div_stat.busy))
        else $error("last word did not start division");

    // Loading the summary starts a fresh run
    a_clear_run: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (vcnt_reg == '0 && item_reg == '0 && !found_reg && m_valid_reg))
        else $error("run state not cleared after summary");

    // A run without valid readings reports zero statistics
    a_empty_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !res_any_reg) |->
            (res_min_reg == '0 && res_max_reg == '0 && res_avg_reg == '0))
        else $error("empty run with nonzero statistics");

    // First critical position is only kept alongside its flag
    a_fpos_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        !found_reg |-> (fpos_reg == '0))
        else $error("critical position without flag");
`endif

endmodule
